>>> rtl/core/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg: shared types and constants of the melody tone sequencer
// Field widths, op codes, clock constants and the divider request/response.
// ----------------------------------------------------------------------------
package mts_pkg;

  // Score memory geometry
  localparam int unsigned SCORE_DEPTH = 512;
  localparam int unsigned SCORE_AW    = $clog2(SCORE_DEPTH);
  localparam int unsigned ENTRY_W     = 22;

  // Field widths
  localparam int unsigned OP_W     = 4;
  localparam int unsigned IDX_W    = 9;
  localparam int unsigned FREQ_W   = 11;
  localparam int unsigned DUR_W    = 11;
  localparam int unsigned FSH_W    = FREQ_W + 2;  // frequency after octave shift
  localparam int unsigned TICKS_W  = 9;
  localparam int unsigned PERIOD_W = 14;
  localparam int unsigned HIGH_W   = 13;
  localparam int unsigned DIVR_W   = 5;
  localparam int unsigned OCT_W    = 3;

  // Shared divider geometry
  localparam int unsigned DIVD_W    = 20;
  localparam int unsigned DIVS_W    = 13;
  localparam int unsigned DIV_CNT_W = $clog2(DIVD_W + 1);

  // Timer clocks and limits
  localparam logic [DIVD_W-1:0]   PWM_CLOCK    = DIVD_W'(1000000);
  localparam logic [DIVD_W-1:0]   TOGGLE_CLOCK = DIVD_W'(500000);
  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = PERIOD_W'(16383);
  localparam logic [DIVR_W-1:0]   DIV_RESET    = DIVR_W'(20);
  localparam logic [DIVR_W-1:0]   DIV_STEP     = DIVR_W'(5);
  localparam logic [DIVR_W-1:0]   DIV_MIN      = DIVR_W'(5);
  localparam logic [DIVR_W-1:0]   DIV_MAX      = DIVR_W'(30);
  localparam logic signed [OCT_W-1:0] OCT_MIN  = -3'sd1;
  localparam logic signed [OCT_W-1:0] OCT_ONE  = 3'sd1;
  localparam logic signed [OCT_W-1:0] OCT_MAX  = 3'sd2;

  // Op codes of an input word
  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 4'd0,
    OP_LOAD   = 4'd1,
    OP_PLAY   = 4'd2,
    OP_STOP   = 4'd3,
    OP_DIV_DN = 4'd4,
    OP_DIV_UP = 4'd5,
    OP_OCT_DN = 4'd6,
    OP_OCT_UP = 4'd7,
    OP_MODE   = 4'd8
  } op_e;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/core/mts_if.sv
// ----------------------------------------------------------------------------
// mts_if: input and result channels of the melody tone sequencer
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface mts_in_if import mts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [IDX_W-1:0]  entry_index;
  logic [FREQ_W-1:0] entry_freq;
  logic [DUR_W-1:0]  entry_dur;

  modport source (output valid, output op, output entry_index, output entry_freq,
                  output entry_dur, input ready);
  modport sink   (input valid, input op, input entry_index, input entry_freq,
                  input entry_dur, output ready);
endinterface

interface mts_out_if import mts_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    tone_on;
  logic [PERIOD_W-1:0]     period;
  logic [HIGH_W-1:0]       high_time;
  logic                    playing;
  logic [IDX_W-1:0]        note_pointer;
  logic                    toggle_mode;
  logic signed [OCT_W-1:0] octave_level;
  logic [DIVR_W-1:0]       tempo_divisor;

  modport source (output valid, output tone_on, output period, output high_time,
                  output playing, output note_pointer, output toggle_mode,
                  output octave_level, output tempo_divisor, input ready);
  modport sink   (input valid, input tone_on, input period, input high_time,
                  input playing, input note_pointer, input toggle_mode,
                  input octave_level, input tempo_divisor, output ready);
endinterface

>>> rtl/core/melody_tone_sequencer.sv
// ----------------------------------------------------------------------------
// melody_tone_sequencer: score-driven tone sequencer
// Plays note entries from a score RAM on ticks; one shared divider scales
// durations and computes timer periods.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  item_i    in   valid/ready    op, entry_index, entry_freq, entry_dur
//  result_o  out  valid/ready    tone_on, period, high_time, playing,
//                                note_pointer, toggle_mode, octave_level,
//                                tempo_divisor
//
//  A word that does not fetch goes through S_OUT into the result register,
//  and the sequencer then idles and takes the next word. A tick that fetches
//  a note goes through S_FETCH and S_DUR, and for a sounding note S_PER, before
//  S_OUT: the 20-step divider runs once for the duration and, for a sounding
//  note, once more for the period. item_i.ready is high only while the
//  sequencer idles.
//  Reset is asynchronous and active low; the score RAM keeps its contents.
//  A stalled result holds in the output register and the sequencer waits.
// ----------------------------------------------------------------------------
module melody_tone_sequencer import mts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  mts_in_if.sink   item_i,
  mts_out_if.source result_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_DUR,
    S_PER,
    S_OUT
  } state_e;

  state_e                  state_q;
  logic                    play_q;
  logic [SCORE_AW-1:0]     ptr_q;
  logic [TICKS_W-1:0]      ticks_q;
  logic [PERIOD_W-1:0]     tperiod_q;
  logic                    sound_q;
  logic [DIVR_W-1:0]       divr_q;
  logic signed [OCT_W-1:0] oct_q;
  logic                    mode_q;
  logic [FSH_W-1:0]        freq_q;
  div_req_t                div_req_q;
  logic                    ov_q;

  logic                  in_accept;
  logic                  ram_we;
  logic [ENTRY_W-1:0]    ram_rdata;
  logic [FREQ_W-1:0]     freq_raw;
  logic [FSH_W-1:0]      freq_sh;
  logic [SCORE_AW-1:0]   ptr_next;
  logic [DIVR_W:0]       divr_up;
  div_rsp_t              div_rsp;

  assign item_i.ready = (state_q == S_IDLE);
  assign in_accept    = item_i.valid && item_i.ready;

  // Score RAM: write on load, always read at the fetch pointer
  assign ram_we = in_accept && (op_e'(item_i.op) == OP_LOAD) &&
                  (32'(item_i.entry_index) < SCORE_DEPTH);

  mts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SCORE_DEPTH)
  ) u_score_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (SCORE_AW'(item_i.entry_index)),
    .wdata_i ({item_i.entry_dur, item_i.entry_freq}),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  mts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  // Octave shift of the fetched frequency; halving truncates
  assign freq_raw = ram_rdata[FREQ_W-1:0];
  always_comb begin
    unique case (oct_q)
      OCT_MIN: freq_sh = FSH_W'(freq_raw >> 1);
      OCT_ONE: freq_sh = FSH_W'({freq_raw, 1'b0});
      OCT_MAX: freq_sh = {freq_raw, 2'b00};
      default: freq_sh = FSH_W'(freq_raw);
    endcase
  end

  assign ptr_next = (ptr_q == SCORE_AW'(SCORE_DEPTH - 1)) ? '0 : ptr_q + SCORE_AW'(1);
  assign divr_up  = {1'b0, divr_q} + {1'b0, DIV_STEP};

  // Sequencer, player state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      play_q    <= 1'b0;
      ptr_q     <= '0;
      ticks_q   <= '0;
      tperiod_q <= '0;
      sound_q   <= 1'b0;
      divr_q    <= DIV_RESET;
      oct_q     <= '0;
      mode_q    <= 1'b0;
      freq_q    <= '0;
      div_req_q <= '0;
      ov_q      <= 1'b0;
      result_o.tone_on       <= 1'b0;
      result_o.period        <= '0;
      result_o.high_time     <= '0;
      result_o.playing       <= 1'b0;
      result_o.note_pointer  <= '0;
      result_o.toggle_mode   <= 1'b0;
      result_o.octave_level  <= '0;
      result_o.tempo_divisor <= DIV_RESET;
    end else begin
      div_req_q.start <= 1'b0;
      if (result_o.valid && result_o.ready) begin
        ov_q <= 1'b0;
      end

      unique case (state_q)
        // Decode an accepted word
        S_IDLE: begin
          if (in_accept) begin
            state_q <= S_OUT;
            unique case (op_e'(item_i.op))
              OP_TICK: begin
                if (play_q) begin
                  if (ticks_q != '0) begin
                    ticks_q <= ticks_q - TICKS_W'(1);
                  end else begin
                    state_q <= S_FETCH;
                  end
                end else begin
                  sound_q <= 1'b0;
                end
              end
              OP_PLAY: begin
                // keep the low address bits so the start wraps into the score
                play_q  <= 1'b1;
                ptr_q   <= SCORE_AW'(item_i.entry_index);
                ticks_q <= '0;
                sound_q <= 1'b0;
              end
              OP_STOP: begin
                play_q  <= 1'b0;
                ptr_q   <= '0;
                ticks_q <= '0;
                sound_q <= 1'b0;
              end
              OP_DIV_DN: begin
                divr_q <= (divr_q >= DIV_MIN + DIV_STEP) ? divr_q - DIV_STEP : DIV_MIN;
              end
              OP_DIV_UP: begin
                divr_q <= (divr_up > {1'b0, DIV_MAX}) ? DIV_MAX : divr_up[DIVR_W-1:0];
              end
              OP_OCT_DN: begin
                if (oct_q > OCT_MIN) begin
                  oct_q <= oct_q - OCT_ONE;
                end
              end
              OP_OCT_UP: begin
                if (oct_q < OCT_MAX) begin
                  oct_q <= oct_q + OCT_ONE;
                end
              end
              OP_MODE: begin
                mode_q <= ~mode_q;
              end
              default: begin
              end
            endcase
          end
        end

        // Entry is on the RAM read port: shift frequency, divide duration
        S_FETCH: begin
          freq_q    <= freq_sh;
          div_req_q <= '{start: 1'b1,
                         dividend: DIVD_W'(ram_rdata[ENTRY_W-1:FREQ_W]),
                         divisor: DIVS_W'(divr_q)};
          state_q   <= S_DUR;
        end

        // Duration ready: end of score, rest, or start the period division
        S_DUR: begin
          if (div_rsp.done) begin
            if (freq_q == '0 && div_rsp.quotient == '0) begin
              ptr_q   <= '0;
              play_q  <= 1'b0;
              sound_q <= 1'b0;
              ticks_q <= '0;
              state_q <= S_OUT;
            end else begin
              ticks_q <= div_rsp.quotient[TICKS_W-1:0];
              ptr_q   <= ptr_next;
              if (freq_q == '0) begin
                sound_q <= 1'b0;
                state_q <= S_OUT;
              end else begin
                div_req_q <= '{start: 1'b1,
                               dividend: mode_q ? TOGGLE_CLOCK : PWM_CLOCK,
                               divisor: DIVS_W'(freq_q)};
                state_q   <= S_PER;
              end
            end
          end
        end

        // Period ready: saturate and sound the note
        S_PER: begin
          if (div_rsp.done) begin
            tperiod_q <= (div_rsp.quotient > DIVD_W'(PERIOD_MAX)) ?
                         PERIOD_MAX : div_rsp.quotient[PERIOD_W-1:0];
            sound_q   <= 1'b1;
            state_q   <= S_OUT;
          end
        end

        // Hand the result word to the output register once it is free
        S_OUT: begin
          if (!ov_q || result_o.ready) begin
            ov_q                   <= 1'b1;
            result_o.tone_on       <= sound_q;
            result_o.period        <= sound_q ? tperiod_q : '0;
            result_o.high_time     <= sound_q ? tperiod_q[PERIOD_W-1:1] : '0;
            result_o.playing       <= play_q;
            result_o.note_pointer  <= IDX_W'(ptr_q);
            result_o.toggle_mode   <= mode_q;
            result_o.octave_level  <= oct_q;
            result_o.tempo_divisor <= divr_q;
            state_q                <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign result_o.valid = ov_q;

endmodule

>>> rtl/core/mts_ram.sv
// ----------------------------------------------------------------------------
// mts_ram: generic single-clock RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/mts_div.sv
// ----------------------------------------------------------------------------
// mts_div: shared restoring divider
// One quotient bit per cycle; done pulses once when the quotient holds.
// ----------------------------------------------------------------------------
module mts_div import mts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIVS_W-1:0]    rem_q;
  logic [DIVD_W-1:0]    quo_q;
  logic [DIVS_W-1:0]    dvs_q;

  logic [DIVS_W:0]   part;
  logic [DIVS_W:0]   diff;
  logic              fits;
  logic [DIVS_W-1:0] rem_d;
  logic [DIVD_W-1:0] quo_d;

  // Trial subtract of one step
  always_comb begin
    part  = {rem_q, quo_q[DIVD_W-1]};
    diff  = part - {1'b0, dvs_q};
    fits  = part >= {1'b0, dvs_q};
    rem_d = fits ? diff[DIVS_W-1:0] : part[DIVS_W-1:0];
    quo_d = {quo_q[DIVD_W-2:0], fits};
  end

  // Load, iterate, finish
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIVD_W);
        rem_q  <= '0;
        quo_q  <= req_i.dividend;
        dvs_q  <= req_i.divisor;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o = '{done: done_q, quotient: quo_q};

endmodule

>>> rtl/core/mts_checker.sv
// ----------------------------------------------------------------------------
// mts_checker: port-level checks of the melody tone sequencer
// Watches the channel ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module mts_checker import mts_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic                tone_on_i,
  input logic [PERIOD_W-1:0] period_i,
  input logic [HIGH_W-1:0]   high_time_i,
  input logic                playing_i,
  input logic [IDX_W-1:0]    note_pointer_i,
  input logic [DIVR_W-1:0]   tempo_divisor_i
);

  // Input is not ready in the cycle after each accepted word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("mts: input accepted in the cycle after an accept");

  // Tempo divisor stays clamped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> tempo_divisor_i >= DIV_MIN && tempo_divisor_i <= DIV_MAX)
    else $error("mts: tempo divisor out of range");

  // Silent tone shows no period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !tone_on_i |-> period_i == '0 && high_time_i == '0)
    else $error("mts: period shown while tone is off");

  // Stopped playback is silent and rewound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !playing_i |-> !tone_on_i && note_pointer_i == '0)
    else $error("mts: stopped playback with tone or pointer set");

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(period_i) &&
                                    $stable(note_pointer_i))
    else $error("mts: stalled result changed");

endmodule

bind melody_tone_sequencer mts_checker u_mts_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (item_i.valid),
  .in_ready_i      (item_i.ready),
  .out_valid_i     (result_o.valid),
  .out_ready_i     (result_o.ready),
  .tone_on_i       (result_o.tone_on),
  .period_i        (result_o.period),
  .high_time_i     (result_o.high_time),
  .playing_i       (result_o.playing),
  .note_pointer_i  (result_o.note_pointer),
  .tempo_divisor_i (result_o.tempo_divisor)
);
